>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TCPF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tcpf assertion failed");

// Property checked at every clock edge, reset included.
`define TCPF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tcpf assertion failed");

`endif

>>> rtl/core/tcpf_pkg.sv
// Types, constants and register codes of the two-charge potential field grid.
package tcpf_pkg;

  localparam int GRID_POINTS = 128;
  localparam int ROW_W       = 8;
  localparam int COL_W       = 7;
  localparam int ADDR_W      = COL_W + 1;
  localparam int RAM_DEPTH   = 2 * GRID_POINTS;
  localparam int VAL_W       = 48;
  localparam int SQ_W        = 58;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int SQ_REM_W    = ROOT_W + 5;
  localparam int QUO_W       = 47;
  localparam int NUM_SHIFT   = 40;
  localparam int SAT_W       = ROOT_W + QUO_W - NUM_SHIFT;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_CHARGE_A     = 3'd0,
    REG_CHARGE_A_X   = 3'd1,
    REG_CHARGE_A_Y   = 3'd2,
    REG_CHARGE_B     = 3'd3,
    REG_CHARGE_B_X   = 3'd4,
    REG_CHARGE_B_Y   = 3'd5,
    REG_GRID_STEP    = 3'd6,
    REG_INV_TWO_STEP = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] grid_row;
    logic [COL_W-1:0] grid_col;
  } point_t;

  typedef struct packed {
    logic [6:0]              out_row;
    logic [6:0]              out_col;
    logic signed [VAL_W-1:0] potential;
    logic signed [VAL_W-1:0] field_x;
    logic signed [VAL_W-1:0] field_y;
  } result_t;

  typedef struct packed {
    logic signed [31:0] charge_a;
    logic [31:0]        charge_a_x;
    logic [31:0]        charge_a_y;
    logic signed [31:0] charge_b;
    logic [31:0]        charge_b_x;
    logic [31:0]        charge_b_y;
    logic [31:0]        grid_step;
    logic [31:0]        inv_two_step;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tag_t;

  typedef struct packed {
    tag_t                    tag;
    logic signed [VAL_W-1:0] pot;
  } item_t;

endpackage

>>> rtl/core/tcpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tcpf_isqrt.sv
// Pipelined floor square root, two lanes, one result bit per stage.
module tcpf_isqrt import tcpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  tag_t              in_tag,
  input  logic [SQ_W-1:0]   in_a,
  input  logic [SQ_W-1:0]   in_b,
  output logic              out_valid,
  output tag_t              out_tag,
  output logic [ROOT_W-1:0] out_a,
  output logic [ROOT_W-1:0] out_b
);

  logic                sv   [ROOT_W+1];
  tag_t                stag [ROOT_W+1];
  logic [SQ_W-1:0]     val  [2][ROOT_W+1];
  logic [SQ_REM_W-1:0] rem  [2][ROOT_W+1];
  logic [ROOT_W-1:0]   root [2][ROOT_W+1];

  assign sv[0]      = in_valid;
  assign stag[0]    = in_tag;
  assign val[0][0]  = in_a;
  assign val[1][0]  = in_b;
  assign rem[0][0]  = '0;
  assign rem[1][0]  = '0;
  assign root[0][0] = '0;
  assign root[1][0] = '0;

  for (genvar s = 1; s <= ROOT_W; s++) begin : g_stage
    localparam int I = ROOT_W - s;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s] <= 1'b0;
      end else if (en) begin
        sv[s] <= sv[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stag[s] <= stag[s-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [SQ_REM_W-1:0] rem_sh;
      logic [SQ_REM_W-1:0] trial;
      logic                ge;

      assign rem_sh = {rem[l][s-1][SQ_REM_W-3:0], val[l][s-1][2*I+1 -: 2]};
      assign trial  = SQ_REM_W'({root[l][s-1], 2'b01});
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          val[l][s]  <= val[l][s-1];
          rem[l][s]  <= ge ? rem_sh - trial : rem_sh;
          root[l][s] <= {root[l][s-1][ROOT_W-2:0], ge};
        end
      end
    end
  end

  assign out_valid = sv[ROOT_W];
  assign out_tag   = stag[ROOT_W];
  assign out_a     = root[0][ROOT_W];
  assign out_b     = root[1][ROOT_W];

endmodule

>>> rtl/core/tcpf_div.sv
// Pipelined restoring divider for |q|*2^40/r, two lanes, one quotient bit per stage.
module tcpf_div import tcpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  tag_t              in_tag,
  input  logic [ROOT_W-1:0] in_ra,
  input  logic [ROOT_W-1:0] in_rb,
  output logic              out_valid,
  output tag_t              out_tag,
  output logic              out_zero,
  output logic [QUO_W-1:0]  out_q_a,
  output logic [QUO_W-1:0]  out_q_b,
  output logic              out_sat_a,
  output logic              out_sat_b
);

  logic [31:0]       mag  [2];
  logic              sv   [QUO_W+1];
  tag_t              stag [QUO_W+1];
  logic              sz   [QUO_W+1];
  logic [ROOT_W-1:0] r    [2][QUO_W+1];
  logic [ROOT_W-1:0] rem  [2][QUO_W+1];
  logic [QUO_W-1:0]  q    [2][QUO_W+1];
  logic              sat  [2][QUO_W+1];

  assign mag[0] = cfg.charge_a[31] ? ~cfg.charge_a + 32'd1 : cfg.charge_a;
  assign mag[1] = cfg.charge_b[31] ? ~cfg.charge_b + 32'd1 : cfg.charge_b;

  assign sv[0]   = in_valid;
  assign stag[0] = in_tag;
  assign sz[0]   = (in_ra == '0) || (in_rb == '0);
  assign r[0][0] = in_ra;
  assign r[1][0] = in_rb;

  for (genvar l = 0; l < 2; l++) begin : g_init
    assign rem[l][0] = ROOT_W'(mag[l] >> (QUO_W - NUM_SHIFT));
    assign q[l][0]   = '0;
    assign sat[l][0] = SAT_W'(mag[l]) >= {r[l][0], {(QUO_W-NUM_SHIFT){1'b0}}};
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
    localparam int I = QUO_W - s;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s] <= 1'b0;
      end else if (en) begin
        sv[s] <= sv[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stag[s] <= stag[s-1];
        sz[s]   <= sz[s-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic            nb;
      logic [ROOT_W:0] rem_t;
      logic [ROOT_W:0] diff;
      logic            ge;

      if (I >= NUM_SHIFT) begin : g_num
        assign nb = mag[l][I-NUM_SHIFT];
      end else begin : g_zero
        assign nb = 1'b0;
      end

      assign rem_t = {rem[l][s-1], nb};
      assign ge    = rem_t >= {1'b0, r[l][s-1]};
      assign diff  = rem_t - {1'b0, r[l][s-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          r[l][s]   <= r[l][s-1];
          sat[l][s] <= sat[l][s-1];
          rem[l][s] <= ge ? diff[ROOT_W-1:0] : rem_t[ROOT_W-1:0];
          q[l][s]   <= {q[l][s-1][QUO_W-2:0], ge};
        end
      end
    end
  end

  assign out_valid = sv[QUO_W];
  assign out_tag   = stag[QUO_W];
  assign out_zero  = sz[QUO_W];
  assign out_q_a   = q[0][QUO_W];
  assign out_q_b   = q[1][QUO_W];
  assign out_sat_a = sat[0][QUO_W];
  assign out_sat_b = sat[1][QUO_W];

endmodule

>>> rtl/core/tcpf_front.sv
// Front end: accepts grid points, filters them and computes the point potential.
module tcpf_front import tcpf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  cfg_t   cfg,
  input  logic   in_valid,
  input  point_t in_point,
  output logic   out_valid,
  output item_t  out_item
);

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic signed [VAL_W-1:0] charge_term(
    input logic neg, input logic sat, input logic [QUO_W-1:0] quo);
    logic [VAL_W-1:0] mq;
    mq = VAL_W'(quo);
    if (sat) begin
      charge_term = neg ? VAL_MIN : VAL_MAX;
    end else begin
      charge_term = neg ? -mq : mq;
    end
  endfunction

  // position
  logic [38:0] xp;
  logic [39:0] yp;
  logic        keep;
  logic        v1;
  tag_t        tag1;
  logic [31:0] x1, y1;

  assign xp   = 39'(cfg.grid_step) * 39'(in_point.grid_col);
  assign yp   = 40'(cfg.grid_step) * 40'(in_point.grid_row);
  assign keep = in_valid && (in_point.grid_row <= ROW_W'(GRID_POINTS))
                && (ROW_W'(in_point.grid_col) < ROW_W'(GRID_POINTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1 <= '{row: in_point.grid_row, col: in_point.grid_col};
      x1   <= (|xp[38:32]) ? '1 : xp[31:0];
      y1   <= (|yp[39:32]) ? '1 : yp[31:0];
    end
  end

  // offsets
  logic        v2;
  tag_t        tag2;
  logic [31:0] dxa, dya, dxb, dyb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag2 <= tag1;
      dxa  <= abs_diff(x1, cfg.charge_a_x);
      dya  <= abs_diff(y1, cfg.charge_a_y);
      dxb  <= abs_diff(x1, cfg.charge_b_x);
      dyb  <= abs_diff(y1, cfg.charge_b_y);
    end
  end

  // squares, Q8.48
  logic        v3;
  tag_t        tag3;
  logic [63:0] pxa, pya, pxb, pyb;
  logic [55:0] sxa, sya, sxb, syb;

  assign pxa = 64'(dxa) * 64'(dxa);
  assign pya = 64'(dya) * 64'(dya);
  assign pxb = 64'(dxb) * 64'(dxb);
  assign pyb = 64'(dyb) * 64'(dyb);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3 <= tag2;
      sxa  <= pxa[63:8];
      sya  <= pya[63:8];
      sxb  <= pxb[63:8];
      syb  <= pyb[63:8];
    end
  end

  // squared distances
  logic        v4;
  tag_t        tag4;
  logic [56:0] da, db;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag4 <= tag3;
      da   <= {1'b0, sxa} + {1'b0, sya};
      db   <= {1'b0, sxb} + {1'b0, syb};
    end
  end

  logic              sq_valid;
  tag_t              sq_tag;
  logic [ROOT_W-1:0] ra, rb;

  tcpf_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_tag    (tag4),
    .in_a      (SQ_W'(da)),
    .in_b      (SQ_W'(db)),
    .out_valid (sq_valid),
    .out_tag   (sq_tag),
    .out_a     (ra),
    .out_b     (rb)
  );

  logic             dv_valid;
  tag_t             dv_tag;
  logic             dv_zero;
  logic [QUO_W-1:0] qa, qb;
  logic             sat_a, sat_b;

  tcpf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (sq_valid),
    .in_tag    (sq_tag),
    .in_ra     (ra),
    .in_rb     (rb),
    .out_valid (dv_valid),
    .out_tag   (dv_tag),
    .out_zero  (dv_zero),
    .out_q_a   (qa),
    .out_q_b   (qb),
    .out_sat_a (sat_a),
    .out_sat_b (sat_b)
  );

  logic signed [VAL_W-1:0] ta, tb;
  logic signed [VAL_W:0]   tsum;
  logic signed [VAL_W-1:0] pot;

  always_comb begin
    ta   = charge_term(cfg.charge_a[31], sat_a, qa);
    tb   = charge_term(cfg.charge_b[31], sat_b, qb);
    tsum = {ta[VAL_W-1], ta} + {tb[VAL_W-1], tb};
    if (dv_zero) begin
      pot = '0;
    end else if (tsum[VAL_W] != tsum[VAL_W-1]) begin
      pot = tsum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      pot = tsum[VAL_W-1:0];
    end
  end

  assign out_valid    = dv_valid;
  assign out_item.tag = dv_tag;
  assign out_item.pot = pot;

endmodule

>>> rtl/core/tcpf_queue.sv
// Short FIFO between the potential front end and the field back end.
module tcpf_queue import tcpf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = count == '0;
  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/core/tcpf_back.sv
// Back end: row store, central differences and the result register.
module tcpf_back import tcpf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  item_t   head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int RD_ABOVE  = 0;
  localparam int RD_CENTER = 1;
  localparam int RD_LEFT   = 2;
  localparam int RD_RIGHT  = 3;
  localparam int RD_PORTS  = 4;

  function automatic logic signed [VAL_W-1:0] scale_out(
    input logic zero, input logic neg, input logic [80:0] prod);
    logic [VAL_W-1:0] m;
    m = prod[63:16];
    if (zero) begin
      scale_out = '0;
    end else if (|prod[80:63]) begin
      scale_out = neg ? VAL_MIN : VAL_MAX;
    end else begin
      scale_out = neg ? -m : m;
    end
  endfunction

  logic en;
  assign en  = !result_valid || !result_stall;
  assign pop = en && !q_empty;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr [RD_PORTS];
  logic [VAL_W-1:0]    rdata [RD_PORTS];

  assign we    = pop && (head.tag.row != ROW_W'(GRID_POINTS));
  assign waddr = {head.tag.row[0], head.tag.col};
  assign raddr[RD_ABOVE]  = {head.tag.row[0], head.tag.col};
  assign raddr[RD_CENTER] = {~head.tag.row[0], head.tag.col};
  assign raddr[RD_LEFT]   = {~head.tag.row[0], head.tag.col - COL_W'(1)};
  assign raddr[RD_RIGHT]  = {~head.tag.row[0], head.tag.col + COL_W'(1)};

  // every copy holds both rows, one read port each
  for (genvar k = 0; k < RD_PORTS; k++) begin : g_ram
    tcpf_ram #(.WIDTH(VAL_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (head.pot),
      .re    (en),
      .raddr (raddr[k]),
      .rdata (rdata[k])
    );
  end

  // read stage
  logic                    b1_v;
  tag_t                    b1_tag;
  logic signed [VAL_W-1:0] b1_pot;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (en) begin
      b1_v <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_tag <= head.tag;
      b1_pot <= head.pot;
    end
  end

  logic [ROW_W-1:0]      orow;
  logic                  border;
  logic signed [VAL_W:0] dx, dy;

  assign orow   = b1_tag.row - ROW_W'(1);
  assign border = (orow == '0) || (orow == ROW_W'(GRID_POINTS - 1))
                  || (b1_tag.col == '0) || (b1_tag.col == COL_W'(GRID_POINTS - 1));
  assign dx = {rdata[RD_LEFT][VAL_W-1], rdata[RD_LEFT]}
              - {rdata[RD_RIGHT][VAL_W-1], rdata[RD_RIGHT]};
  assign dy = {rdata[RD_ABOVE][VAL_W-1], rdata[RD_ABOVE]} - {b1_pot[VAL_W-1], b1_pot};

  // difference stage
  logic               b2_v, b2_report;
  logic [6:0]         b2_row, b2_col;
  logic [VAL_W-1:0]   b2_center;
  logic               b2_negx, b2_negy, b2_zx, b2_zy;
  logic [VAL_W:0]     b2_magx, b2_magy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else if (en) begin
      b2_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_report <= b1_tag.row != '0;
      b2_row    <= orow[6:0];
      b2_col    <= b1_tag.col;
      b2_center <= rdata[RD_CENTER];
      b2_negx   <= dx[VAL_W];
      b2_negy   <= dy[VAL_W];
      b2_magx   <= dx[VAL_W] ? -dx : dx;
      b2_magy   <= dy[VAL_W] ? -dy : dy;
      b2_zx     <= border;
      b2_zy     <= border || (rdata[RD_CENTER] == '0);
    end
  end

  // partial products
  logic             b3_v, b3_report;
  logic [6:0]       b3_row, b3_col;
  logic [VAL_W-1:0] b3_center;
  logic             b3_negx, b3_negy, b3_zx, b3_zy;
  logic [63:0]      b3_lox, b3_loy;
  logic [48:0]      b3_hix, b3_hiy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_v <= 1'b0;
    end else if (en) begin
      b3_v <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_report <= b2_report;
      b3_row    <= b2_row;
      b3_col    <= b2_col;
      b3_center <= b2_center;
      b3_negx   <= b2_negx;
      b3_negy   <= b2_negy;
      b3_zx     <= b2_zx;
      b3_zy     <= b2_zy;
      b3_lox    <= 64'(b2_magx[31:0]) * 64'(cfg.inv_two_step);
      b3_loy    <= 64'(b2_magy[31:0]) * 64'(cfg.inv_two_step);
      b3_hix    <= 49'(b2_magx[VAL_W:32]) * 49'(cfg.inv_two_step);
      b3_hiy    <= 49'(b2_magy[VAL_W:32]) * 49'(cfg.inv_two_step);
    end
  end

  logic [80:0] prodx, prody;
  assign prodx = {b3_hix, 32'b0} + 81'(b3_lox);
  assign prody = {b3_hiy, 32'b0} + 81'(b3_loy);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= b3_v && b3_report;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.out_row   <= b3_row;
      result.out_col   <= b3_col;
      result.potential <= b3_center;
      result.field_x   <= scale_out(b3_zx, b3_negx, prodx);
      result.field_y   <= scale_out(b3_zy, b3_negy, prody);
    end
  end

endmodule

>>> rtl/core/two_charge_potential_field_grid_top.sv
// Top level of the two-charge potential and field grid engine.
// Takes one grid point per clock and delivers one result per clock while nothing stalls.
// A point's potential comes out of an 80-stage pipeline (position, offsets, squares,
// squared distances, a 29-stage square root and a 47-stage divider, one bit per stage); a
// four-entry queue then feeds the field stage, which reads four copies of the 256 x 48 row
// store, one read port each, and passes through the difference and partial-product stages
// to the result register. A point is reported one row after it is streamed.
// Stalling the result side backs up through the queue into the point channel.
module two_charge_potential_field_grid_top import tcpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        point_valid,
  output logic        point_stall,
  input  point_t      point,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHARGE_A:     cfg.charge_a     <= cfg_data;
        REG_CHARGE_A_X:   cfg.charge_a_x   <= cfg_data;
        REG_CHARGE_A_Y:   cfg.charge_a_y   <= cfg_data;
        REG_CHARGE_B:     cfg.charge_b     <= cfg_data;
        REG_CHARGE_B_X:   cfg.charge_b_x   <= cfg_data;
        REG_CHARGE_B_Y:   cfg.charge_b_y   <= cfg_data;
        REG_GRID_STEP:    cfg.grid_step    <= cfg_data;
        REG_INV_TWO_STEP: cfg.inv_two_step <= cfg_data;
        default:          cfg.grid_step    <= cfg.grid_step;
      endcase
    end
  end

  logic  q_full, q_empty, pop;
  logic  f_valid;
  item_t f_item, head;

  assign point_stall = q_full;

  tcpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (!q_full),
    .cfg       (cfg),
    .in_valid  (point_valid),
    .in_point  (point),
    .out_valid (f_valid),
    .out_item  (f_item)
  );

  tcpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && !q_full),
    .push_item (f_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tcpf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> rtl/core/tcpf_checker.sv
// Port-level checker for the grid engine, bound to the top level.
`include "assert_macros.svh"

module tcpf_checker import tcpf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `TCPF_ASSERT(a_result_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result))
  `TCPF_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid)
  `TCPF_ASSERT(a_border_col, clk, rst, result_valid && (result.out_col == '0) |-> (result.field_x == '0) && (result.field_y == '0))
  `TCPF_ASSERT(a_border_row, clk, rst, result_valid && (result.out_row == '0) |-> (result.field_x == '0) && (result.field_y == '0))
  `TCPF_ASSERT(a_zero_pot, clk, rst, result_valid && (result.potential == '0) |-> result.field_y == '0)

endmodule

bind two_charge_potential_field_grid_top tcpf_checker u_tcpf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

>>> verif/tb_top.sv
// Self-checking testbench for the two-charge potential and field grid engine.
module tb_top import tcpf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 2 * GRID_POINTS + 120;

  logic        clk;
  logic        rst;
  logic        point_valid;
  logic        point_stall;
  point_t      point;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  two_charge_potential_field_grid_top dut (.*);

  cfg_t    cur_cfg;
  longint  row_pots [RAM_DEPTH];
  result_t pending_results [$];
  int      errors;
  bit      calm;
  int      hold_request;
  int      stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > longint'(VAL_MAX)) return longint'(VAL_MAX);
    if (v < longint'(VAL_MIN)) return longint'(VAL_MIN);
    return v;
  endfunction

  function automatic longint unsigned grid_pos(int idx);
    longint unsigned p;
    p = {32'd0, cur_cfg.grid_step} * longint'(idx);
    return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
  endfunction

  function automatic longint unsigned sq_offset(longint unsigned a, longint unsigned b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return (d * d) >> 8;
  endfunction

  function automatic longint coulomb_term(logic signed [31:0] q, longint unsigned r);
    longint unsigned mag, num, quo, rem, res;
    mag = (q < 0) ? longint'(-longint'(q)) : longint'(q);
    num = mag << 24;
    quo = num / r;
    rem = num % r;
    if (quo >= (64'd1 << 31)) return (q < 0) ? longint'(VAL_MIN) : longint'(VAL_MAX);
    res = (quo << 16) + (rem << 16) / r;
    return (q < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint potential_at(int row, int col);
    longint unsigned x, y, ra, rb;
    x = grid_pos(col);
    y = grid_pos(row);
    ra = int_sqrt(sq_offset(x, cur_cfg.charge_a_x) + sq_offset(y, cur_cfg.charge_a_y));
    rb = int_sqrt(sq_offset(x, cur_cfg.charge_b_x) + sq_offset(y, cur_cfg.charge_b_y));
    if (ra == 0 || rb == 0) return 0;
    return clamp48(coulomb_term(cur_cfg.charge_a, ra) + coulomb_term(cur_cfg.charge_b, rb));
  endfunction

  function automatic longint scaled_diff(longint diff);
    longint unsigned inv, mag, m;
    inv = {32'd0, cur_cfg.inv_two_step};
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    if (inv != 0 && mag > 64'h7FFF_FFFF_FFFF_FFFF / inv)
      return (diff < 0) ? longint'(VAL_MIN) : longint'(VAL_MAX);
    m = (mag * inv) >> 16;
    return (diff < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void predict_point(point_t p);
    int      row, col, cur, base, o;
    longint  above, v, ex, ey;
    result_t r;
    row = p.grid_row;
    col = p.grid_col;
    if (row > GRID_POINTS || col >= GRID_POINTS) return;
    cur = (row & 1) * GRID_POINTS + col;
    above = row_pots[cur];
    if (row < GRID_POINTS) row_pots[cur] = potential_at(row, col);
    if (row == 0) return;
    o = row - 1;
    base = (o & 1) * GRID_POINTS;
    v = row_pots[base + col];
    ex = 0;
    ey = 0;
    if (!(o == 0 || o == GRID_POINTS - 1 || col == 0 || col == GRID_POINTS - 1)) begin
      ex = scaled_diff(row_pots[base + col - 1] - row_pots[base + col + 1]);
      if (v != 0) ey = scaled_diff(above - row_pots[cur]);
    end
    r.out_row   = o[6:0];
    r.out_col   = col[6:0];
    r.potential = v[VAL_W-1:0];
    r.field_x   = ex[VAL_W-1:0];
    r.field_y   = ey[VAL_W-1:0];
    pending_results.push_back(r);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: row %0d col %0d", result.out_row, result.out_col);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (result.out_row !== e.out_row) begin
          $error("out_row expected %0d got %0d", e.out_row, result.out_row); errors++;
        end
        if (result.out_col !== e.out_col) begin
          $error("out_col expected %0d got %0d", e.out_col, result.out_col); errors++;
        end
        if (result.potential !== e.potential) begin
          $error("potential expected %0d got %0d", e.potential, result.potential); errors++;
        end
        if (result.field_x !== e.field_x) begin
          $error("field_x expected %0d got %0d", e.field_x, result.field_x); errors++;
        end
        if (result.field_y !== e.field_y) begin
          $error("field_y expected %0d got %0d", e.field_y, result.field_y); errors++;
        end
      end
    end
  end

  // ---------------- point and config side ----------------
  task automatic send_point(input int row, input int col);
    point_t p;
    int     gap;
    p.grid_row = row[ROW_W-1:0];
    p.grid_col = col[COL_W-1:0];
    point <= p;
    point_valid <= 1'b1;
    do @(posedge clk); while (point_stall);
    predict_point(p);
    gap = (calm || $urandom_range(0, 9) < 7) ? 0 : pick_gap();
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    point_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    cfg_reg_t    idx;
    logic [31:0] val;
    wait_drained();
    idx = idx.first();
    do begin
      case (idx)
        REG_CHARGE_A:     val = c.charge_a;
        REG_CHARGE_A_X:   val = c.charge_a_x;
        REG_CHARGE_A_Y:   val = c.charge_a_y;
        REG_CHARGE_B:     val = c.charge_b;
        REG_CHARGE_B_X:   val = c.charge_b_x;
        REG_CHARGE_B_Y:   val = c.charge_b_y;
        REG_GRID_STEP:    val = c.grid_step;
        default:          val = c.inv_two_step;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid <= 1'b0;
    cur_cfg = c;
    @(posedge clk);
  endtask

  function automatic cfg_t nominal_cfg();
    cfg_t c;
    c.grid_step    = 32'h0020_4081;
    c.inv_two_step = 32'd4161536;
    c.charge_a     = 32'sd1000;
    c.charge_a_x   = c.grid_step * 40;
    c.charge_a_y   = c.grid_step * 60;
    c.charge_b     = -32'sd500;
    c.charge_b_x   = 32'h0A00_0000;
    c.charge_b_y   = 32'h0500_0000;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.grid_step    = $urandom_range(0, 32'h0400_0000);
    c.inv_two_step = $urandom;
    c.charge_a     = $urandom;
    c.charge_b     = $urandom;
    c.charge_a_x   = c.grid_step * $urandom_range(0, 127);
    c.charge_a_y   = ($urandom_range(0, 1)) ? c.grid_step * $urandom_range(0, 127) : $urandom;
    c.charge_b_x   = $urandom;
    c.charge_b_y   = $urandom;
    return c;
  endfunction

  task automatic random_traffic(input int budget);
    int sent, r0, c0, nrows, ncols;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        r0 = $urandom_range(0, GRID_POINTS);
        nrows = $urandom_range(1, 4);
        c0 = $urandom_range(0, GRID_POINTS - 1);
        ncols = $urandom_range(1, 16);
        for (int r = r0; r <= r0 + nrows && r <= GRID_POINTS; r++)
          for (int c = c0; c < c0 + ncols && c < GRID_POINTS; c++) begin
            send_point(r, c);
            sent++;
          end
      end else begin
        r0 = $urandom_range(0, 255);
        send_point(r0, $urandom_range(0, GRID_POINTS - 1));
        if (r0 <= GRID_POINTS) sent++;
      end
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_fill_rows();
    load_config(nominal_cfg());
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < GRID_POINTS; c++) send_point(r, c);
  endtask

  task automatic test_directed_points();
    cfg_t c;
    c = nominal_cfg();
    load_config(c);
    calm = 1'b1;
    for (int r = 59; r <= 61; r++)
      for (int k = 39; k <= 41; k++) send_point(r, k);
    send_point(0, 0);
    send_point(1, 127);
    send_point(126, 0);
    send_point(127, 127);
    send_point(GRID_POINTS, 0);
    send_point(GRID_POINTS, 127);
    send_point(129, 5);
    send_point(255, 127);
    calm = 1'b0;
    c.charge_a = 32'sh7FFF_FFFF; c.charge_b = 32'sh8000_0000;
    c.charge_a_x = 0; c.charge_a_y = 0;
    c.charge_b_x = 32'hFFFF_FFFF; c.charge_b_y = 32'hFFFF_FFFF;
    c.grid_step = 32'hFFFF_FFFF; c.inv_two_step = 32'hFFFF_FFFF;
    load_config(c);
    for (int r = 0; r <= 2; r++)
      for (int k = 0; k <= 3; k++) send_point(r, k);
    send_point(GRID_POINTS, 1);
    c.grid_step = 0; c.inv_two_step = 0;
    load_config(c);
    for (int k = 0; k < 4; k++) send_point(1, k);
    c = nominal_cfg();
    c.grid_step = 32'h0000_0100; c.charge_a_x = 32'h0000_0002; c.charge_a_y = 0;
    c.inv_two_step = 32'hFFFF_FFFF;
    load_config(c);
    for (int r = 0; r <= 3; r++)
      for (int k = 0; k <= 4; k++) send_point(r, k);
  endtask

  task automatic test_random_configs();
    load_config(nominal_cfg());
    random_traffic(300);
    for (int n = 0; n < 4; n++) begin
      load_config(random_cfg());
      calm = (n == 1);
      random_traffic(250);
      calm = 1'b0;
    end
  endtask

  task automatic test_output_backpressure();
    load_config(random_cfg());
    hold_request = 400;
    calm = 1'b1;
    for (int c = 0; c < GRID_POINTS; c++) send_point(10, c);
    for (int c = 0; c < GRID_POINTS; c++) send_point(11, c);
    calm = 1'b0;
    wait_drained();
    for (int c = 0; c < 40; c++) send_point(12, c);
  endtask

  initial begin
    rst = 1'b1;
    point_valid = 1'b0;
    point = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    result_stall = 1'b0;
    errors = 0;
    calm = 1'b0;
    hold_request = 0;
    cur_cfg = '0;
    foreach (row_pots[i]) row_pots[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_rows();
    test_directed_points();
    test_random_configs();
    test_output_backpressure();
    wait_drained();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
